@@ design/tslv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tslv_pkg
// Types, constants and helpers for the tangent-space light vector pipeline.
// ----------------------------------------------------------------------------
package tslv_pkg;

    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_LIGHT = 8'd3;

    localparam logic signed [31:0] LIGHT_Z_RESET = 32'sd65536;

    // stage map
    localparam int ST_DIFF     = 0;
    localparam int ST_ABS      = 1;
    localparam int ST_MAX      = 2;
    localparam int ST_MSB      = 3;
    localparam int ST_SHIFT    = 4;
    localparam int ST_SQUARE   = 5;
    localparam int ST_SUM      = 6;
    localparam int SQRT_STEPS  = 31;
    localparam int ST_SQRT0    = 7;
    localparam int ST_DIVINIT  = ST_SQRT0 + SQRT_STEPS;
    localparam int DIV_STEPS   = 15;
    localparam int ST_DIV0     = ST_DIVINIT + 1;
    localparam int ST_LVEC     = ST_DIV0 + DIV_STEPS;
    localparam int ST_PROD     = ST_LVEC + 1;
    localparam int ST_ACC      = ST_PROD + 1;
    localparam int NUM_STAGES  = ST_ACC + 1;

    typedef struct packed {
        logic [2:0][15:0]       nrm;
        logic [2:0][15:0]       stan;
        logic [2:0][15:0]       ttan;
        logic [2:0][32:0]       dif;
        logic [2:0][32:0]       mag;
        logic [2:0]             neg;
        logic [32:0]            mx;
        logic [5:0]             msb;
        logic                   zero;
        logic [2:0][59:0]       sq;
        logic [61:0]            rad;
        logic [34:0]            rem;
        logic [30:0]            root;
        logic [2:0][44:0]       dnum;
        logic [2:0][31:0]       rdiv;
        logic [2:0][14:0]       quo;
        logic [2:0][31:0]       lvec;
        logic [2:0][2:0][47:0]  prod;
        logic [2:0][49:0]       acc;
    } pipe_t;

    // position of the highest set bit
    function automatic logic [5:0] msb_pos(input logic [32:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 33; i++) begin
            if (v[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

endpackage

@@ design/tangent_space_light_vector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tangent_space_light_vector
// Per-vertex DOT3 light vector in tangent space, fully pipelined.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake           Payload
// s_       in   s_tvalid/s_tready   vertex, normal, s and t tangents
// m_       out  m_tvalid/m_tready   light_s, light_t, light_n
// cfg_     in   cfg_valid/cfg_ready light registers
//
// One item per cycle while the skid is empty; the pipeline holds the 31-step square root
// and the 15-step divider stages.
// Synchronous active-low reset clears valid bits and resets the light registers (light_z to 65536).
// A one-item skid behind the output register takes the item in flight when
// m_tready drops; the pipeline then holds until the skid drains.
module tangent_space_light_vector (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vertex_x, vertex_y, vertex_z, normal_x/y/z, s_tangent_x/y/z, t_tangent_x/y/z
    input  logic [239:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // light_s, light_t, light_n
    output logic [47:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int NS = tslv_pkg::NUM_STAGES;

    logic signed [31:0] light_x_reg, light_y_reg, light_z_reg;
    logic               point_light_reg;
    logic [2:0][31:0]   light_v;

    tslv_pkg::pipe_t pipe_reg  [NS];
    tslv_pkg::pipe_t pipe_next [NS];
    logic [NS-1:0]   valid_reg;

    logic        en;
    logic [47:0] res;
    logic        m_valid_reg, skid_valid_reg;
    logic [47:0] m_data_reg, skid_reg;

    assign cfg_ready = 1'b1;
    assign light_v   = {light_z_reg, light_y_reg, light_x_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_x_reg     <= '0;
            light_y_reg     <= '0;
            light_z_reg     <= tslv_pkg::LIGHT_Z_RESET;
            point_light_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tslv_pkg::REG_LIGHT_X:     light_x_reg     <= cfg_data;
                tslv_pkg::REG_LIGHT_Y:     light_y_reg     <= cfg_data;
                tslv_pkg::REG_LIGHT_Z:     light_z_reg     <= cfg_data;
                tslv_pkg::REG_POINT_LIGHT: point_light_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_stage
            if (g == tslv_pkg::ST_DIFF) begin : g_diff
                always_comb begin
                    tslv_pkg::pipe_t w;
                    w = '0;
                    for (int i = 0; i < 3; i++) begin
                        w.dif[i] = {light_v[i][31], light_v[i]}
                                 - {s_tdata[32*i+31], s_tdata[32*i +: 32]};
                        w.nrm[i]  = s_tdata[96  + 16*i +: 16];
                        w.stan[i] = s_tdata[144 + 16*i +: 16];
                        w.ttan[i] = s_tdata[192 + 16*i +: 16];
                    end
                    pipe_next[g] = w;
                end
            end else if (g == tslv_pkg::ST_ABS) begin : g_abs
                always_comb begin
                    tslv_pkg::pipe_t w;
                    w = pipe_reg[g-1];
                    for (int i = 0; i < 3; i++) begin
                        w.neg[i] = w.dif[i][32];
                        w.mag[i] = w.dif[i][32] ? 33'(-w.dif[i]) : w.dif[i];
                    end
                    pipe_next[g] = w;
                end
            end else if (g == tslv_pkg::ST_MAX) begin : g_max
                always_comb begin
                    tslv_pkg::pipe_t w;
                    logic [32:0] m01;
                    w = pipe_reg[g-1];
                    m01  = (w.mag[1] > w.mag[0]) ? w.mag[1] : w.mag[0];
                    w.mx = (w.mag[2] > m01) ? w.mag[2] : m01;
                    pipe_next[g] = w;
                end
            end else if (g == tslv_pkg::ST_MSB) begin : g_msb
                always_comb begin
                    tslv_pkg::pipe_t w;
                    w = pipe_reg[g-1];
                    w.msb  = tslv_pkg::msb_pos(w.mx);
                    w.zero = (w.mx == '0);
                    pipe_next[g] = w;
                end
            end else if (g == tslv_pkg::ST_SHIFT) begin : g_shift
                always_comb begin
                    tslv_pkg::pipe_t w;
                    w = pipe_reg[g-1];
                    for (int i = 0; i < 3; i++) begin
                        if (w.msb >= 6'd29) begin
                            w.mag[i] = w.mag[i] >> (w.msb - 6'd29);
                        end else begin
                            w.mag[i] = w.mag[i] << (6'd29 - w.msb);
                        end
                    end
                    pipe_next[g] = w;
                end
            end else if (g == tslv_pkg::ST_SQUARE) begin : g_sq
                always_comb begin
                    tslv_pkg::pipe_t w;
                    w = pipe_reg[g-1];
                    for (int i = 0; i < 3; i++) begin
                        w.sq[i] = w.mag[i][29:0] * w.mag[i][29:0];
                    end
                    pipe_next[g] = w;
                end
            end else if (g == tslv_pkg::ST_SUM) begin : g_sum
                always_comb begin
                    tslv_pkg::pipe_t w;
                    w = pipe_reg[g-1];
                    w.rad  = 62'(w.sq[0]) + 62'(w.sq[1]) + 62'(w.sq[2]);
                    w.rem  = '0;
                    w.root = '0;
                    pipe_next[g] = w;
                end
            end else if (g < tslv_pkg::ST_DIVINIT) begin : g_sqrt
                localparam int PI = 30 - (g - tslv_pkg::ST_SQRT0);
                always_comb begin
                    tslv_pkg::pipe_t w;
                    logic [34:0] tr, trial;
                    w = pipe_reg[g-1];
                    tr    = {w.rem[32:0], w.rad[2*PI+1 -: 2]};
                    trial = {2'b00, w.root, 2'b01};
                    if (tr >= trial) begin
                        w.rem  = tr - trial;
                        w.root = {w.root[29:0], 1'b1};
                    end else begin
                        w.rem  = tr;
                        w.root = {w.root[29:0], 1'b0};
                    end
                    pipe_next[g] = w;
                end
            end else if (g == tslv_pkg::ST_DIVINIT) begin : g_divinit
                always_comb begin
                    tslv_pkg::pipe_t w;
                    w = pipe_reg[g-1];
                    for (int i = 0; i < 3; i++) begin
                        w.dnum[i] = {1'b0, w.mag[i][29:0], 14'd0} + 45'(w.root[30:1]);
                        w.rdiv[i] = {2'b00, w.dnum[i][44:15]};
                        w.quo[i]  = '0;
                    end
                    pipe_next[g] = w;
                end
            end else if (g < tslv_pkg::ST_LVEC) begin : g_div
                localparam int QB = 14 - (g - tslv_pkg::ST_DIV0);
                always_comb begin
                    tslv_pkg::pipe_t w;
                    logic [32:0] t;
                    w = pipe_reg[g-1];
                    for (int i = 0; i < 3; i++) begin
                        t = {w.rdiv[i], w.dnum[i][QB]};
                        if (t >= {2'b00, w.root}) begin
                            w.rdiv[i]    = 32'(t - {2'b00, w.root});
                            w.quo[i][QB] = 1'b1;
                        end else begin
                            w.rdiv[i] = t[31:0];
                        end
                    end
                    pipe_next[g] = w;
                end
            end else if (g == tslv_pkg::ST_LVEC) begin : g_lvec
                always_comb begin
                    tslv_pkg::pipe_t w;
                    w = pipe_reg[g-1];
                    for (int i = 0; i < 3; i++) begin
                        if (!point_light_reg) begin
                            w.lvec[i] = light_v[i];
                        end else if (w.zero) begin
                            w.lvec[i] = '0;
                        end else if (w.neg[i]) begin
                            w.lvec[i] = -{17'd0, w.quo[i]};
                        end else begin
                            w.lvec[i] = {17'd0, w.quo[i]};
                        end
                    end
                    pipe_next[g] = w;
                end
            end else if (g == tslv_pkg::ST_PROD) begin : g_prod
                always_comb begin
                    tslv_pkg::pipe_t w;
                    w = pipe_reg[g-1];
                    for (int c = 0; c < 3; c++) begin
                        w.prod[0][c] = $signed(w.stan[c]) * $signed(w.lvec[c]);
                        w.prod[1][c] = $signed(w.ttan[c]) * $signed(w.lvec[c]);
                        w.prod[2][c] = $signed(w.nrm[c])  * $signed(w.lvec[c]);
                    end
                    pipe_next[g] = w;
                end
            end else begin : g_acc
                always_comb begin
                    tslv_pkg::pipe_t w;
                    w = pipe_reg[g-1];
                    for (int v = 0; v < 3; v++) begin
                        w.acc[v] = 50'($signed(w.prod[v][0])) + 50'($signed(w.prod[v][1]))
                                 + 50'($signed(w.prod[v][2]));
                    end
                    pipe_next[g] = w;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    pipe_reg[g] <= pipe_next[g];
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NS-2:0], s_tvalid};
        end
    end

    // round half up and saturate
    always_comb begin
        logic signed [50:0] rs, sh;
        res = '0;
        for (int v = 0; v < 3; v++) begin
            rs = 51'($signed(pipe_reg[NS-1].acc[v]))
               + (point_light_reg ? 51'sd8192 : 51'sd32768);
            sh = point_light_reg ? (rs >>> 14) : (rs >>> 16);
            if (sh > 51'sd32767) begin
                res[16*v +: 16] = 16'h7fff;
            end else if (sh < -51'sd32768) begin
                res[16*v +: 16] = 16'h8000;
            end else begin
                res[16*v +: 16] = sh[15:0];
            end
        end
    end

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_valid_reg && !m_tready) begin
            if (en && valid_reg[NS-1]) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            m_valid_reg    <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= valid_reg[NS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid_reg && !m_tready) begin
            if (en && valid_reg[NS-1]) begin
                skid_reg <= res;
            end
        end else if (skid_valid_reg) begin
            m_data_reg <= skid_reg;
        end else begin
            m_data_reg <= res;
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tangent-space light vector pipeline. Vertices
// go in with random gaps and output back-pressure; each result is predicted
// from the current light registers and checked in order.
// ----------------------------------------------------------------------------

class light_scoreboard;
    logic signed [31:0] lx, ly, lz;
    logic               positional;
    logic [47:0]        pending[$];
    int                 errors;
    int                 shown;

    function void clear();
        lx = 0;
        ly = 0;
        lz = tslv_pkg::LIGHT_Z_RESET;
        positional = 0;
        pending.delete();
        errors = 0;
        shown = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] val);
        case (idx)
            tslv_pkg::REG_LIGHT_X:     lx = val;
            tslv_pkg::REG_LIGHT_Y:     ly = val;
            tslv_pkg::REG_LIGHT_Z:     lz = val;
            tslv_pkg::REG_POINT_LIGHT: positional = val[0];
            default: ;
        endcase
    endfunction

    function logic [15:0] sat(longint v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    function longint rshift(longint x, int k);
        return (x + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function longint usqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function void note_vertex(logic [239:0] d);
        longint lv[3], nv[3], sv[3], tv[3], dl[3];
        longint unsigned a[3], mx, len, q;
        longint ds, dt, dn;
        int k;
        for (int i = 0; i < 3; i++) begin
            nv[i] = longint'($signed(d[96 + 16*i +: 16]));
            sv[i] = longint'($signed(d[144 + 16*i +: 16]));
            tv[i] = longint'($signed(d[192 + 16*i +: 16]));
        end
        if (positional) begin
            dl[0] = longint'(lx) - longint'($signed(d[31:0]));
            dl[1] = longint'(ly) - longint'($signed(d[63:32]));
            dl[2] = longint'(lz) - longint'($signed(d[95:64]));
            mx = 0;
            for (int i = 0; i < 3; i++) begin
                a[i] = dl[i] < 0 ? -dl[i] : dl[i];
                if (a[i] > mx) mx = a[i];
            end
            if (mx == 0) begin
                lv = '{0, 0, 0};
            end else begin
                while (mx >= (64'd1 << 30)) begin
                    for (int i = 0; i < 3; i++) a[i] >>= 1;
                    mx >>= 1;
                end
                while (mx < (64'd1 << 29)) begin
                    for (int i = 0; i < 3; i++) a[i] <<= 1;
                    mx <<= 1;
                end
                len = usqrt(a[0]*a[0] + a[1]*a[1] + a[2]*a[2]);
                for (int i = 0; i < 3; i++) begin
                    q = (a[i] * 16384 + len / 2) / len;
                    lv[i] = dl[i] < 0 ? -longint'(q) : longint'(q);
                end
            end
            k = 14;
        end else begin
            lv[0] = lx;
            lv[1] = ly;
            lv[2] = lz;
            k = 16;
        end
        ds = rshift(sv[0]*lv[0] + sv[1]*lv[1] + sv[2]*lv[2], k);
        dt = rshift(tv[0]*lv[0] + tv[1]*lv[1] + tv[2]*lv[2], k);
        dn = rshift(nv[0]*lv[0] + nv[1]*lv[1] + nv[2]*lv[2], k);
        pending.push_back({sat(dn), sat(dt), sat(ds)});
    endfunction

    function void check_result(logic [47:0] got);
        logic [47:0] exp_v;
        if (pending.size() == 0) begin
            errors++;
            if (shown < 10) begin
                shown++;
                $display("unexpected result %h", got);
            end
            return;
        end
        exp_v = pending.pop_front();
        for (int f = 0; f < 3; f++) begin
            if (got[16*f +: 16] !== exp_v[16*f +: 16]) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("field %0d mismatch: expected %h got %h", f,
                             exp_v[16*f +: 16], got[16*f +: 16]);
                end
            end
        end
    endfunction
endclass

module tb_top;
    localparam int LATENCY = 58;
    localparam int STALL_LIMIT = 20000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [239:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [47:0]  m_tdata;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [7:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    light_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;
    int  quiet;

    tangent_space_light_vector i_dut (.*);

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_vertex(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (aresetn && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("FAIL tangent_space_light_vector");
            $finish;
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_tready <= 0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        cfg_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_light(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit pos);
        drain();
        write_reg(tslv_pkg::REG_LIGHT_X, x);
        write_reg(tslv_pkg::REG_LIGHT_Y, y);
        write_reg(tslv_pkg::REG_LIGHT_Z, z);
        write_reg(tslv_pkg::REG_POINT_LIGHT, {31'd0, pos});
        cfg_valid <= 0;
    endtask

    task automatic send(logic [239:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tdata <= d;
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] unit_ish();
        case ($urandom_range(4))
            0: return 16'h4000;
            1: return 16'hc000;
            2: return 16'h8000;
            3: return 16'h7fff;
            default: return 16'($urandom_range(32767) - 16384);
        endcase
    endfunction

    function automatic logic [239:0] rand_vertex(bit near);
        logic [239:0] d;
        for (int i = 0; i < 3; i++)
            d[32*i +: 32] = near ? 32'($signed($urandom_range(0, 2*65536*8)) - 65536*8)
                                 : $urandom;
        for (int i = 0; i < 9; i++)
            d[96 + 16*i +: 16] = $urandom_range(1) ? unit_ish() : 16'($urandom);
        return d;
    endfunction

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) send(rand_vertex($urandom_range(3) != 0));
    endtask

    initial begin
        logic [239:0] d;
        sb = new();
        sb.clear();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        quiet = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: reset light, extremes, unit axes
        d = '0;
        d[96 +: 48] = {16'h4000, 16'h0000, 16'h0000};
        d[144 +: 48] = {16'h0000, 16'h0000, 16'h4000};
        d[192 +: 48] = {16'h0000, 16'h4000, 16'h0000};
        send(d);
        send({{9{16'h8000}}, 96'h0});
        send({{9{16'h7fff}}, {3{32'h7fffffff}}});
        send({{9{16'h8000}}, {3{32'h80000000}}});
        drain();
        write_reg(8'd7, 32'hffffffff);
        set_light(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
        send({{9{16'h7fff}}, 96'h0});
        send({{9{16'h8000}}, 96'h0});
        set_light(32'h0, 32'h0, 32'h00010000, 1);
        d = '0;
        d[96 +: 144] = {9{16'h4000}};
        d[95:64] = 32'h00010000;
        send(d);                    // vertex on the light
        d[95:64] = 32'h80000000;
        send(d);
        set_light(32'h80000000, 32'h80000000, 32'h80000000, 1);
        send({{9{16'h8000}}, {3{32'h7fffffff}}});
        send({{9{16'h7fff}}, {3{32'h7fffffff}}});
        send({{9{16'h4000}}, 32'h80000001, 32'h80000000, 32'h80000000});

        for (int ph = 0; ph < 8; ph++) begin
            set_light($urandom_range(3) ? 32'($signed($urandom_range(0, 65536*16)) - 65536*8)
                                        : $urandom,
                      $urandom, $urandom_range(1) ? 32'h00010000 : $urandom,
                      ph % 2 == 0);
            case (ph % 4)
                0: random_phase(250, 0, 0);
                1: random_phase(250, 62, 0);
                2: random_phase(250, 0, 62);
                default: random_phase(250, 22, 22);
            endcase
        end

        // long receiver hold while input keeps coming
        drain();
        hold_cycles = 400;
        random_phase(150, 0, 0);

        drain();
        if (sb.errors == 0) begin
            $display("PASS tangent_space_light_vector");
        end else begin
            $display("FAIL tangent_space_light_vector");
        end
        $finish;
    end
endmodule

@@ sim.f @@
design/tslv_pkg.sv
design/tangent_space_light_vector.sv
tb/tb_top.sv
